[hw/rtl/btq_pkg.sv]
// Shared types and constants of the bitmap text quad generator.
`timescale 1ns / 1ps

package btq_pkg;

  // Character codes
  localparam logic [7:0] CodeNewline  = 8'd10;
  localparam logic [7:0] CodeFirst    = 8'd32;
  localparam logic [7:0] CodeLast     = 8'd126;
  localparam logic [7:0] CodeQuestion = 8'd63;

  // Saturation limits
  localparam logic [19:0] PosMax    = 20'hFFFFF;
  localparam logic [16:0] TexOne    = 17'h10000;
  localparam logic [15:0] CountMax  = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ATLAS_COLUMNS = 3'd0,
    REG_U_STEP        = 3'd1,
    REG_V_STEP        = 3'd2,
    REG_GLYPH_WIDTH   = 3'd3,
    REG_GLYPH_HEIGHT  = 3'd4,
    REG_PEN_ADVANCE   = 3'd5
  } btq_reg_e;

  typedef struct packed {
    logic [7:0]  atlas_columns;
    logic [16:0] u_step;
    logic [16:0] v_step;
    logic [11:0] glyph_width;
    logic [11:0] glyph_height;
    logic [15:0] pen_advance;
  } btq_cfg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_of_text;
  } btq_in_t;

  typedef struct packed {
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [1:0]  corner;
    logic [15:0] quad_number;
    logic        last_of_glyph;
  } btq_out_t;

  // Classified character handed from the front to the back
  typedef struct packed {
    logic       newline;
    logic       start;
    logic [6:0] col;
    logic [6:0] row;
  } btq_job_t;

endpackage

[hw/rtl/btq_front.sv]
// Front end: accepts characters, maps them to atlas cells, splits column and row.
`timescale 1ns / 1ps

module btq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         cols_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  btq_pkg::btq_in_t   in_data_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output btq_pkg::btq_job_t  job_o
);
  import btq_pkg::*;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } fs_state_e;

  fs_state_e  state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] dvd_q, dvd_d;   // dividend, quotient shifts in from the bottom
  logic [7:0] rem_q, rem_d;
  logic       nl_q, nl_d;
  logic       start_q, start_d;
  logic [7:0] cols_eff;
  logic [7:0] idx;
  logic [8:0] step_a, step_b;
  logic [7:0] code;

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic din,
                                          input logic [7:0] d);
    logic [8:0] trial;
    trial = {rem, din};
    if (trial >= {1'b0, d}) begin
      div_step = {1'b1, 8'(trial - {1'b0, d})};
    end else begin
      div_step = {1'b0, trial[7:0]};
    end
  endfunction

  assign code     = in_data_i.char_code;
  assign cols_eff = (cols_i == 8'd0) ? 8'd1 : cols_i;

  // Unprintable bytes draw as the question mark cell
  always_comb begin
    if (code < CodeFirst || code > CodeLast) begin
      idx = CodeQuestion - CodeFirst;
    end else begin
      idx = code - CodeFirst;
    end
  end

  // Two division steps per cycle
  assign step_a = div_step(rem_q, dvd_q[7], cols_eff);
  assign step_b = div_step(step_a[7:0], dvd_q[6], cols_eff);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    nl_d    = nl_q;
    start_d = start_q;
    unique case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          nl_d    = (code == CodeNewline);
          start_d = in_data_i.start_of_text;
          dvd_d   = idx;
          rem_d   = 8'd0;
          cnt_d   = 2'd0;
          state_d = (code == CodeNewline) ? FS_PUSH : FS_DIV;
        end
      end
      FS_DIV: begin
        dvd_d = {dvd_q[5:0], step_a[8], step_b[8]};
        rem_d = step_b[7:0];
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (job_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    nl_q    <= nl_d;
    start_q <= start_d;
  end

  assign in_ready_o    = (state_q == FS_IDLE);
  assign job_valid_o   = (state_q == FS_PUSH);
  assign job_o.newline = nl_q;
  assign job_o.start   = start_q;
  assign job_o.col     = rem_q[6:0];
  assign job_o.row     = dvd_q[6:0];

endmodule

[hw/rtl/btq_fifo.sv]
// Small job queue between the front and back ends.
`timescale 1ns / 1ps

module btq_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  btq_pkg::btq_job_t  push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output btq_pkg::btq_job_t  pop_data_o
);
  import btq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  btq_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/btq_back.sv]
// Back end: keeps the pen, computes quad corners and sends four vertices per glyph.
`timescale 1ns / 1ps

module btq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btq_pkg::btq_cfg_t  cfg_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  btq_pkg::btq_job_t  job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output btq_pkg::btq_out_t  out_data_o
);
  import btq_pkg::*;

  typedef enum logic [2:0] {
    BS_IDLE = 3'b001,
    BS_MUL  = 3'b010,
    BS_EMIT = 3'b100
  } bs_state_e;

  localparam logic [1:0] CornerLast = 2'd3;

  bs_state_e   state_q, state_d;
  logic [19:0] pen_x_q, pen_x_d;
  logic [19:0] pen_y_q, pen_y_d;
  logic [15:0] qc_q, qc_d;
  logic [1:0]  corner_q, corner_d;

  // Glyph payload registers
  logic [19:0] x0_q, x1_q, y0_q, y1_q;
  logic [15:0] qn_q;
  logic [6:0]  col_q, row_q;
  logic [16:0] u0_q, u1_q, v0_q, v1_q;

  logic [19:0] base_x, base_y;
  logic [15:0] base_qc;
  logic [19:0] x1_sum, y1_sum, adv_sum;
  logic        pop;

  function automatic logic [19:0] sat_pos(input logic [20:0] v);
    sat_pos = v[20] ? PosMax : v[19:0];
  endfunction

  function automatic logic [16:0] sat_tex(input logic [24:0] v);
    sat_tex = (v > 25'(TexOne)) ? TexOne : v[16:0];
  endfunction

  // Pen as seen by the popped job, after an optional start reset
  assign base_x  = job_i.start ? '0 : pen_x_q;
  assign base_y  = job_i.start ? '0 : pen_y_q;
  assign base_qc = job_i.start ? '0 : qc_q;
  assign x1_sum  = sat_pos({1'b0, base_x} + 21'({cfg_i.glyph_width, 4'b0000}));
  assign y1_sum  = sat_pos({1'b0, base_y} + 21'({cfg_i.glyph_height, 4'b0000}));
  assign adv_sum = sat_pos({1'b0, base_x} + 21'(cfg_i.pen_advance));

  assign job_ready_o = (state_q == BS_IDLE);
  assign pop         = job_valid_i && job_ready_o;

  always_comb begin
    state_d  = state_q;
    pen_x_d  = pen_x_q;
    pen_y_d  = pen_y_q;
    qc_d     = qc_q;
    corner_d = corner_q;
    unique case (state_q)
      BS_IDLE: begin
        if (pop) begin
          if (job_i.newline) begin
            pen_x_d = '0;
            pen_y_d = y1_sum;
            qc_d    = base_qc;
          end else begin
            pen_x_d = adv_sum;
            pen_y_d = base_y;
            qc_d    = (base_qc == CountMax) ? base_qc : base_qc + 16'd1;
            state_d = BS_MUL;
          end
        end
      end
      BS_MUL: begin
        corner_d = '0;
        state_d  = BS_EMIT;
      end
      BS_EMIT: begin
        if (out_ready_i) begin
          corner_d = corner_q + 2'd1;
          if (corner_q == CornerLast) begin
            state_d = BS_IDLE;
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BS_IDLE;
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      qc_q     <= '0;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      pen_x_q  <= pen_x_d;
      pen_y_q  <= pen_y_d;
      qc_q     <= qc_d;
      corner_q <= corner_d;
    end
  end

  // Latch glyph geometry at pop
  always_ff @(posedge clk_i) begin
    if (pop && !job_i.newline) begin
      x0_q  <= base_x;
      x1_q  <= x1_sum;
      y0_q  <= base_y;
      y1_q  <= y1_sum;
      qn_q  <= base_qc;
      col_q <= job_i.col;
      row_q <= job_i.row;
    end
  end

  // Texture edges: one multiply each, saturated at 1.0
  always_ff @(posedge clk_i) begin
    if (state_q == BS_MUL) begin
      u0_q <= sat_tex(25'({1'b0, col_q} * cfg_i.u_step));
      u1_q <= sat_tex(25'(({1'b0, col_q} + 8'd1) * cfg_i.u_step));
      v0_q <= sat_tex(25'({1'b0, row_q} * cfg_i.v_step));
      v1_q <= sat_tex(25'(({1'b0, row_q} + 8'd1) * cfg_i.v_step));
    end
  end

  // Vertex select: right for corners 1 and 2, bottom for corners 2 and 3
  logic right, bottom;
  assign right  = (corner_q == 2'd1) || (corner_q == 2'd2);
  assign bottom = corner_q[1];

  assign out_valid_o              = (state_q == BS_EMIT);
  assign out_data_o.pos_x         = right ? x1_q : x0_q;
  assign out_data_o.pos_y         = bottom ? y1_q : y0_q;
  assign out_data_o.tex_u         = right ? u1_q : u0_q;
  assign out_data_o.tex_v         = bottom ? v1_q : v0_q;
  assign out_data_o.corner        = corner_q;
  assign out_data_o.quad_number   = qn_q;
  assign out_data_o.last_of_glyph = (corner_q == CornerLast);

endmodule

[hw/rtl/bitmap_text_quad_generator_unit.sv]
// Top level of the bitmap text quad generator: registers, front, queue, back.
`timescale 1ns / 1ps

// One character per input item. A printable glyph yields four vertex items
// (corners 0..3, last_of_glyph on corner 3); a newline yields none and only
// moves the pen. The front end maps the byte to an atlas cell and splits it
// into column and row with a two-bit-per-cycle divider; the back end takes a
// job, runs the texture multiplies and then sends one vertex per cycle when
// the output is not stalled. The job queue between them lets the divider
// work on the next character while vertices are still going out. Registers
// are written through cfg_we_i/cfg_idx_i/cfg_wdata_i and should only change
// while the block is idle; indexes beyond the list are ignored.
module bitmap_text_quad_generator_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  btq_pkg::btq_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output btq_pkg::btq_out_t  out_data_o
);
  import btq_pkg::*;

  btq_cfg_t cfg_q;
  btq_job_t front_job, back_job;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atlas_columns <= 8'd16;
      cfg_q.u_step        <= 17'd4096;
      cfg_q.v_step        <= 17'd4096;
      cfg_q.glyph_width   <= 12'd8;
      cfg_q.glyph_height  <= 12'd8;
      cfg_q.pen_advance   <= 16'd144;
    end else if (cfg_we_i) begin
      unique case (btq_reg_e'(cfg_idx_i))
        REG_ATLAS_COLUMNS: cfg_q.atlas_columns <= cfg_wdata_i[7:0];
        REG_U_STEP:        cfg_q.u_step        <= cfg_wdata_i;
        REG_V_STEP:        cfg_q.v_step        <= cfg_wdata_i;
        REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_wdata_i[11:0];
        REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= cfg_wdata_i[11:0];
        REG_PEN_ADVANCE:   cfg_q.pen_advance   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  btq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cols_i      (cfg_q.atlas_columns),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  btq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_job)
  );

  btq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[dv/btq_quad_checker.sv]
// Checker for the bitmap text quad generator: mirrors registers and pen state, predicts and compares vertices.
`timescale 1ns / 1ps

module btq_quad_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [16:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  btq_pkg::btq_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  btq_pkg::btq_out_t out_data_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);
  import btq_pkg::*;

  localparam int unsigned PrintLimit = 100;

  localparam logic [1:0] CornerTopLeft     = 2'd0;
  localparam logic [1:0] CornerTopRight    = 2'd1;
  localparam logic [1:0] CornerBottomRight = 2'd2;
  localparam logic [1:0] CornerBottomLeft  = 2'd3;

  localparam btq_cfg_t CfgReset = '{
    atlas_columns: 8'd16,
    u_step:        17'd4096,
    v_step:        17'd4096,
    glyph_width:   12'd8,
    glyph_height:  12'd8,
    pen_advance:   16'd144
  };

  // Register mirror, pen state and vertices still owed by the block
  btq_cfg_t    regs;
  logic [19:0] pen_x;
  logic [19:0] pen_y;
  logic [15:0] quad_count;
  btq_out_t    vertex_q[$];

  function automatic logic [19:0] clamp_pos(input logic [31:0] v);
    return (v > 32'(PosMax)) ? PosMax : v[19:0];
  endfunction

  function automatic logic [16:0] clamp_tex(input logic [31:0] v);
    return (v > 32'(TexOne)) ? TexOne : v[16:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= PrintLimit)
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  // Lay out one character: pen moves, and a glyph queues its four corners
  task automatic lay_out_char(input btq_in_t item);
    int unsigned glyph_idx;
    int unsigned cols;
    int unsigned col;
    int unsigned row;
    logic [19:0] x0, x1, y0, y1;
    logic [16:0] u0, u1, v0, v1;
    logic        right;
    logic        bottom;
    btq_out_t    vtx;
    if (item.start_of_text) begin
      pen_x      = '0;
      pen_y      = '0;
      quad_count = '0;
    end
    if (item.char_code == CodeNewline) begin
      pen_x = '0;
      pen_y = clamp_pos(32'(pen_y) + 32'(regs.glyph_height) * 16);
      return;
    end
    // unprintable bytes borrow the '?' glyph
    if (item.char_code < CodeFirst || item.char_code > CodeLast)
      glyph_idx = 32'(CodeQuestion - CodeFirst);
    else
      glyph_idx = 32'(item.char_code - CodeFirst);
    cols = (regs.atlas_columns == '0) ? 1 : 32'(regs.atlas_columns);
    col  = glyph_idx % cols;
    row  = glyph_idx / cols;
    x0 = pen_x;
    x1 = clamp_pos(32'(pen_x) + 32'(regs.glyph_width) * 16);
    y0 = pen_y;
    y1 = clamp_pos(32'(pen_y) + 32'(regs.glyph_height) * 16);
    u0 = clamp_tex(col * 32'(regs.u_step));
    u1 = clamp_tex((col + 1) * 32'(regs.u_step));
    v0 = clamp_tex(row * 32'(regs.v_step));
    v1 = clamp_tex((row + 1) * 32'(regs.v_step));
    vtx.corner = CornerTopLeft;
    do begin
      right  = (vtx.corner == CornerTopRight) || (vtx.corner == CornerBottomRight);
      bottom = (vtx.corner == CornerBottomRight) || (vtx.corner == CornerBottomLeft);
      vtx.pos_x         = right ? x1 : x0;
      vtx.pos_y         = bottom ? y1 : y0;
      vtx.tex_u         = right ? u1 : u0;
      vtx.tex_v         = bottom ? v1 : v0;
      vtx.quad_number   = quad_count;
      vtx.last_of_glyph = (vtx.corner == CornerBottomLeft);
      vertex_q.insert(vertex_q.size(), vtx);
      vtx.corner++;
    end while (vtx.corner != CornerTopLeft);
    if (quad_count != CountMax)
      quad_count++;
    pen_x = clamp_pos(32'(pen_x) + 32'(regs.pen_advance));
  endtask

  // Compare one delivered vertex against the oldest prediction
  task automatic check_vertex(input btq_out_t got);
    btq_out_t want;
    if (vertex_q.size() == 0) begin
      report_mismatch("unexpected vertex, quad_number", 32'(got.quad_number), '0);
      return;
    end
    want = vertex_q.pop_front();
    if (got.pos_x !== want.pos_x)
      report_mismatch("pos_x", 32'(got.pos_x), 32'(want.pos_x));
    if (got.pos_y !== want.pos_y)
      report_mismatch("pos_y", 32'(got.pos_y), 32'(want.pos_y));
    if (got.tex_u !== want.tex_u)
      report_mismatch("tex_u", 32'(got.tex_u), 32'(want.tex_u));
    if (got.tex_v !== want.tex_v)
      report_mismatch("tex_v", 32'(got.tex_v), 32'(want.tex_v));
    if (got.corner !== want.corner)
      report_mismatch("corner", 32'(got.corner), 32'(want.corner));
    if (got.quad_number !== want.quad_number)
      report_mismatch("quad_number", 32'(got.quad_number), 32'(want.quad_number));
    if (got.last_of_glyph !== want.last_of_glyph)
      report_mismatch("last_of_glyph", 32'(got.last_of_glyph), 32'(want.last_of_glyph));
  endtask

  // Watch register writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs       = CfgReset;
      pen_x      = '0;
      pen_y      = '0;
      quad_count = '0;
      vertex_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATLAS_COLUMNS: regs.atlas_columns = cfg_wdata_i[7:0];
          REG_U_STEP:        regs.u_step        = cfg_wdata_i;
          REG_V_STEP:        regs.v_step        = cfg_wdata_i;
          REG_GLYPH_WIDTH:   regs.glyph_width   = cfg_wdata_i[11:0];
          REG_GLYPH_HEIGHT:  regs.glyph_height  = cfg_wdata_i[11:0];
          REG_PEN_ADVANCE:   regs.pen_advance   = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i)
        check_vertex(out_data_i);
      if (in_valid_i && in_ready_i)
        lay_out_char(in_data_i);
      pending_o <= vertex_q.size();
    end
  end

endmodule

[dv/tb.sv]
// Testbench top for the bitmap text quad generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import btq_pkg::*;

  localparam int unsigned RandomPhases = 4;
  localparam int unsigned PhaseItems   = 16;
  localparam int unsigned LongItems    = 32;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned IdlePct      = 8;

  // zero columns, zero sizes, zero advance, steps past 1.0
  localparam btq_cfg_t CfgDegenerate = '{
    atlas_columns: 8'd0,
    u_step:        17'h1FFFF,
    v_step:        17'h1FFFF,
    glyph_width:   12'd0,
    glyph_height:  12'd0,
    pen_advance:   16'd0
  };

  // largest cells and advance, steps of exactly 1.0
  localparam btq_cfg_t CfgWidest = '{
    atlas_columns: 8'd255,
    u_step:        17'h10000,
    v_step:        17'h10000,
    glyph_width:   12'hFFF,
    glyph_height:  12'hFFF,
    pen_advance:   16'hFFFF
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  btq_in_t     in_data_i   = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  btq_out_t    out_data_o;
  logic        no_idle     = 1'b0;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned stall_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bitmap_text_quad_generator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  btq_quad_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Receiver stalls at random unless a no-idle stretch is running
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  // Watchdog: too long without any item moving ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic btq_in_t char_item(input logic [7:0] code, input logic start);
    btq_in_t item;
    item.char_code     = code;
    item.start_of_text = start;
    return item;
  endfunction

  // Mostly printable text with some newlines, stray bytes and restarts
  function automatic btq_in_t pick_char();
    btq_in_t     item;
    int unsigned r;
    r = $urandom_range(99);
    item.start_of_text = ($urandom_range(99) < 4);
    if (r < 12)
      item.char_code = CodeNewline;
    else if (r < 24)
      item.char_code = 8'($urandom_range(255));
    else
      item.char_code = 8'($urandom_range(CodeLast, CodeFirst));
    return item;
  endfunction

  // Low end, high end, or something in the usual range
  function automatic logic [16:0] pick_field(input int unsigned lo, input int unsigned hi,
                                             input int unsigned mid);
    case ($urandom_range(4))
      0:       return 17'(lo);
      1:       return 17'(hi);
      default: return 17'($urandom_range(mid, lo));
    endcase
  endfunction

  function automatic btq_cfg_t pick_cfg();
    btq_cfg_t c;
    c.atlas_columns = 8'(pick_field(0, 255, 20));
    c.u_step        = pick_field(0, 131071, 65536);
    c.v_step        = pick_field(0, 131071, 65536);
    c.glyph_width   = 12'(pick_field(0, 4095, 64));
    c.glyph_height  = 12'(pick_field(0, 4095, 64));
    c.pen_advance   = 16'(pick_field(0, 65535, 4096));
    return c;
  endfunction

  function automatic logic [16:0] reg_value(input btq_cfg_t c, input btq_reg_e r);
    case (r)
      REG_ATLAS_COLUMNS: return 17'(c.atlas_columns);
      REG_U_STEP:        return c.u_step;
      REG_V_STEP:        return c.v_step;
      REG_GLYPH_WIDTH:   return 17'(c.glyph_width);
      REG_GLYPH_HEIGHT:  return 17'(c.glyph_height);
      default:           return 17'(c.pen_advance);
    endcase
  endfunction

  // Write every register, one per cycle; block must be idle
  task automatic program_regs(input btq_cfg_t c);
    btq_reg_e r;
    r = r.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= r;
      cfg_wdata_i <= reg_value(c, r);
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  // Offer one character and hold it until accepted; valid stays up afterwards
  task automatic send_char(input btq_in_t item);
    if (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending, wait out every owed vertex, then let a trailing newline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    btq_in_t     item;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: code extremes, unprintables, newlines, restarts
    send_char(char_item(CodeFirst, 1'b1));
    send_char(char_item(CodeLast, 1'b0));
    send_char(char_item(8'd65, 1'b0));
    send_char(char_item(8'd0, 1'b0));
    send_char(char_item(8'd31, 1'b0));
    send_char(char_item(8'd127, 1'b0));
    send_char(char_item(8'd128, 1'b0));
    send_char(char_item(8'd255, 1'b0));
    send_char(char_item(CodeNewline, 1'b0));
    send_char(char_item(CodeQuestion, 1'b0));
    send_char(char_item(CodeNewline, 1'b1));
    send_char(char_item(8'd48, 1'b0));
    send_char(char_item(8'd170, 1'b1));
    send_char(char_item(8'd85, 1'b0));
    wait_idle();

    // Degenerate quads, single column, texture saturation
    program_regs(CfgDegenerate);
    send_char(char_item(CodeLast, 1'b1));
    send_char(char_item(CodeFirst, 1'b0));
    send_char(char_item(CodeNewline, 1'b0));
    send_char(char_item(8'd200, 1'b0));
    send_char(char_item(8'd77, 1'b0));
    wait_idle();

    // Largest cells and steps
    program_regs(CfgWidest);
    send_char(char_item(CodeLast, 1'b1));
    send_char(char_item(8'd97, 1'b0));
    send_char(char_item(CodeNewline, 1'b0));
    send_char(char_item(CodeLast, 1'b0));
    wait_idle();

    // Random text under random register settings
    for (phase = 0; phase < RandomPhases; phase++) begin
      program_regs(pick_cfg());
      send_char(char_item(8'($urandom_range(CodeLast, CodeFirst)), 1'b1));
      for (n = 1; n < PhaseItems; n++)
        send_char(pick_char());
      wait_idle();
    end

    // One long text with no idling: the pen runs into saturation
    no_idle <= 1'b1;
    program_regs(CfgWidest);
    send_char(char_item(CodeFirst, 1'b1));
    for (n = 1; n < LongItems; n++) begin
      item = pick_char();
      item.start_of_text = 1'b0;
      send_char(item);
    end
    wait_idle();

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/btq_pkg.sv
hw/rtl/btq_front.sv
hw/rtl/btq_fifo.sv
hw/rtl/btq_back.sv
hw/rtl/bitmap_text_quad_generator_unit.sv
dv/btq_quad_checker.sv
dv/tb.sv
